@@ rtl/evel_pkg.sv @@
package evel_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_REVERSE_LEFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_REVERSE_RIGHT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VELOCITY_SCALE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FILTER_ALPHA   = 3'd3;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ScaleW   = 32;
  localparam int unsigned AlphaW   = 17;
  localparam int unsigned VelW     = 32;
  localparam int unsigned AngleOutW = 14;
  localparam int unsigned DeltaOutW = 15;

  localparam logic [ScaleW-1:0] SCALE_RESET = 32'd327680;
  localparam logic [AlphaW-1:0] ALPHA_RESET = 17'd55450;
  localparam logic [AlphaW-1:0] ALPHA_ONE   = 17'd65536;

  // shared multiplier: 18 x 33 signed
  localparam int unsigned MulAW = 18;
  localparam int unsigned MulBW = 33;
  localparam int unsigned ProdW = MulAW + MulBW;

  // scaled input is Q24.8 from Q16.16 * count, filter result drops the Q1.16 alpha scale
  localparam int unsigned ScaleShift = 8;
  localparam int unsigned AlphaShift = 16;

  typedef struct packed {
    logic                    en;
    logic signed [MulAW-1:0] op_a;
    logic signed [MulBW-1:0] op_b;
  } mul_req_t;

endpackage

@@ rtl/encoder_velocity_estimator.sv @@
// a transfer steps through ST_MUL1, ST_SCALE and ST_MUL2 to ST_FIN, which registers
// the result on out_valid once the output slot is free; one sample is taken at a
// time, since the single shared 18x33 multiplier is used once for scaling and once
// for the low-pass filter; a waiting result does not block the next input transfer
// reset (synchronous, rst_n low): registers to defaults, per-wheel state cleared
module encoder_velocity_estimator #(
  parameter int unsigned ANGLE_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration writes
  input  logic                                   cfg_we,
  input  logic [evel_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [evel_pkg::CfgDataW-1:0]          cfg_wdata,
  // encoder samples
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_wheel,
  input  logic [15:0]                            in_raw_word,
  // velocity results
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_wheel_out,
  output logic [evel_pkg::AngleOutW-1:0]         out_angle,
  output logic signed [evel_pkg::DeltaOutW-1:0]  out_count_delta,
  output logic signed [evel_pkg::VelW-1:0]       out_velocity
);
  import evel_pkg::*;

  // delta is one bit wider than the angle, wrap arithmetic one more
  localparam int unsigned DW  = ANGLE_BITS + 1;
  localparam int unsigned DWW = ANGLE_BITS + 2;
  localparam logic signed [DWW-1:0] FULL = DWW'(1) <<< ANGLE_BITS;
  localparam logic signed [DWW-1:0] HALF = DWW'(1) <<< (ANGLE_BITS - 1);
  localparam int unsigned ShW = ProdW - ScaleShift;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SCALE,
    ST_MUL2,
    ST_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic              rev_left_r;
  logic              rev_right_r;
  logic [ScaleW-1:0] scale_r;
  logic [AlphaW-1:0] alpha_r;

  // per-wheel state
  logic [ANGLE_BITS-1:0]    prev_angle_r [2];
  logic signed [VelW-1:0]   filt_vel_r   [2];
  logic [1:0]               primed_r;

  // working registers of the sample in flight
  logic                     wheel_r;
  logic [ANGLE_BITS-1:0]    angle_r;
  logic signed [DW-1:0]     delta_r;
  logic signed [VelW-1:0]   vin_r;

  // output slot
  logic                     out_valid_r;
  logic                     out_wheel_r;
  logic [AngleOutW-1:0]     out_angle_r;
  logic signed [DeltaOutW-1:0] out_delta_r;
  logic signed [VelW-1:0]   out_vel_r;

  // shared multiplier
  mul_req_t                 mul_req;
  logic signed [ProdW-1:0]  prod_r;

  evel_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  // ---------------------------------------------------------------
  // delta from the incoming word, worked out during the transfer
  // ---------------------------------------------------------------
  logic                   in_xfer;
  logic [ANGLE_BITS-1:0]  ang_new;
  logic [ANGLE_BITS-1:0]  ang_prev;
  logic signed [DWW-1:0]  d_raw;
  logic signed [DWW-1:0]  d_wrap;
  logic signed [DWW-1:0]  d_dir;
  logic                   rev_sel;

  assign in_xfer = in_valid && in_ready;
  assign ang_new = in_raw_word[15 -: ANGLE_BITS];
  // first sample of a wheel primes itself, giving a zero delta
  assign ang_prev = primed_r[in_wheel] ? prev_angle_r[in_wheel] : ang_new;
  assign rev_sel  = in_wheel ? rev_right_r : rev_left_r;

  always_comb begin
    d_raw = DWW'(ang_new) - DWW'(ang_prev);
    // wrap into one half turn either way
    if (d_raw > HALF) begin
      d_wrap = d_raw - FULL;
    end else if (d_raw < -HALF) begin
      d_wrap = d_raw + FULL;
    end else begin
      d_wrap = d_raw;
    end
    d_dir = rev_sel ? -d_wrap : d_wrap;
  end

  // ---------------------------------------------------------------
  // multiplier operand select
  // ---------------------------------------------------------------
  logic [AlphaW-1:0]       alpha_eff;
  logic signed [MulBW-1:0] vel_diff;

  // alpha above one acts as one (no filtering)
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  // filter rewritten as v_prev + a*(in - v_prev), a single product
  assign vel_diff  = MulBW'(vin_r) - MulBW'(filt_vel_r[wheel_r]);

  always_comb begin
    mul_req.en   = 1'b0;
    mul_req.op_a = '0;
    mul_req.op_b = '0;
    case (state_r)
      ST_MUL1: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = MulAW'(delta_r);
        mul_req.op_b = signed'({1'b0, scale_r});
      end
      ST_MUL2: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = signed'({1'b0, alpha_eff});
        mul_req.op_b = vel_diff;
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // round and saturate the scaled count, round the filter step
  // ---------------------------------------------------------------
  logic signed [ProdW-1:0]  scale_rnd;
  logic signed [ShW-1:0]    scale_sh;
  logic [ShW-VelW:0]        scale_hi;
  logic signed [VelW-1:0]   vin_sat;
  logic signed [ProdW-1:0]  filt_rnd;
  logic signed [ProdW-1:0]  filt_step;
  logic signed [VelW-1:0]   vel_new;

  always_comb begin
    // ties go towards plus infinity
    scale_rnd = prod_r + (ProdW'(1) <<< (ScaleShift - 1));
    scale_sh  = ShW'(scale_rnd >>> ScaleShift);
    scale_hi  = scale_sh[ShW-1:VelW-1];
    if (scale_hi == '0 || scale_hi == '1) begin
      vin_sat = scale_sh[VelW-1:0];
    end else if (scale_sh[ShW-1]) begin
      vin_sat = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      vin_sat = {1'b0, {(VelW-1){1'b1}}};
    end
  end

  always_comb begin
    filt_rnd  = prod_r + (ProdW'(1) <<< (AlphaShift - 1));
    filt_step = filt_rnd >>> AlphaShift;
    // result lies between input and previous value, so it fits
    vel_new   = filt_vel_r[wheel_r] + filt_step[VelW-1:0];
  end

  // output slot free or being emptied in this cycle
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  assign in_ready = (state_r == ST_IDLE);

  // ---------------------------------------------------------------
  // sequencer, state and registered outputs
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      rev_left_r    <= 1'b0;
      rev_right_r   <= 1'b0;
      scale_r       <= SCALE_RESET;
      alpha_r       <= ALPHA_RESET;
      primed_r      <= '0;
      prev_angle_r[0] <= '0;
      prev_angle_r[1] <= '0;
      filt_vel_r[0] <= '0;
      filt_vel_r[1] <= '0;
    end else begin
      // configuration writes, unknown indexes ignored
      if (cfg_we) begin
        case (cfg_index)
          REG_REVERSE_LEFT:   rev_left_r  <= cfg_wdata[0];
          REG_REVERSE_RIGHT:  rev_right_r <= cfg_wdata[0];
          REG_VELOCITY_SCALE: scale_r     <= cfg_wdata[ScaleW-1:0];
          REG_FILTER_ALPHA:   alpha_r     <= cfg_wdata[AlphaW-1:0];
          default: ;
        endcase
      end

      // in the final step the slot is refilled instead
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            wheel_r  <= in_wheel;
            angle_r  <= ang_new;
            delta_r  <= DW'(d_dir);
            prev_angle_r[in_wheel] <= ang_new;
            primed_r[in_wheel]     <= 1'b1;
            state_r  <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          vin_r   <= vin_sat;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // hold here until the output slot can take the result
          if (out_free) begin
            filt_vel_r[wheel_r] <= vel_new;
            out_valid_r <= 1'b1;
            out_wheel_r <= wheel_r;
            out_angle_r <= AngleOutW'(angle_r);
            out_delta_r <= DeltaOutW'(delta_r);
            out_vel_r   <= vel_new;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wheel_out   = out_wheel_r;
  assign out_angle       = out_angle_r;
  assign out_count_delta = out_delta_r;
  assign out_velocity    = out_vel_r;

`ifndef SYNTHESIS
  // a transfer starts the multiply sequence straight away
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_MUL1)
    else $error("transfer did not start the sequencer");

  // the wheel of a transfer is primed afterwards
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> primed_r[$past(in_wheel)])
    else $error("wheel not primed after its first sample");

  // finishing with a free slot always presents a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished sample not presented");

  // a result only appears from the final step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result presented outside the final step");
`endif

endmodule

@@ rtl/evel_mul.sv @@
module evel_mul (
  input  logic                              clk,
  input  evel_pkg::mul_req_t                req,
  output logic signed [evel_pkg::ProdW-1:0] prod_r
);
  import evel_pkg::*;

  logic signed [ProdW-1:0] prod_nxt;

  // full-width signed product, registered before any further use
  assign prod_nxt = ProdW'(req.op_a) * ProdW'(req.op_b);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ tb/sv/encoder_velocity_checker.sv @@
`timescale 1ns / 1ps

module encoder_velocity_checker #(
  parameter int unsigned ANGLE_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [evel_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [evel_pkg::CfgDataW-1:0]         cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  in_wheel,
  input  logic [15:0]                           in_raw_word,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  out_wheel_out,
  input  logic [evel_pkg::AngleOutW-1:0]        out_angle,
  input  logic signed [evel_pkg::DeltaOutW-1:0] out_count_delta,
  input  logic signed [evel_pkg::VelW-1:0]      out_velocity,
  output int                                    mismatch_total,
  output int                                    results_pending
);
  import evel_pkg::*;

  localparam int unsigned AngleShift = 16 - ANGLE_BITS;
  localparam longint AngleFull = longint'(1) << ANGLE_BITS;
  localparam longint AngleHalf = AngleFull / 2;
  localparam longint Int32Max  = 64'sd2147483647;
  localparam longint Int32Min  = -64'sd2147483648;

  typedef struct packed {
    logic                        wheel;
    logic [AngleOutW-1:0]        angle;
    logic signed [DeltaOutW-1:0] delta;
    logic signed [VelW-1:0]      velocity;
  } wheel_speed_t;

  wheel_speed_t        expected_speeds[$];
  int                  mismatches = 0;

  logic                reverse_l;
  logic                reverse_r;
  logic [ScaleW-1:0]   mm_per_count;
  logic [AlphaW-1:0]   lowpass_weight;
  longint              last_angle[2];
  longint              smoothed_speed[2];
  bit                  seen_sample[2];

  // nearest, ties towards plus infinity
  function automatic longint round_half_up(longint x, int unsigned sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_int32(longint x);
    if (x > Int32Max) return Int32Max;
    if (x < Int32Min) return Int32Min;
    return x;
  endfunction

  function automatic wheel_speed_t estimate_speed(logic w, logic [15:0] raw);
    longint       ang;
    longint       d;
    longint       scaled;
    longint       a;
    longint       unity;
    longint       acc;
    longint       v;
    wheel_speed_t r;
    ang = longint'(raw >> AngleShift) & (AngleFull - 1);
    if (!seen_sample[w]) begin
      last_angle[w]  = ang;
      seen_sample[w] = 1'b1;
    end
    d = ang - last_angle[w];
    if (d > AngleHalf) d = d - AngleFull;
    if (d < -AngleHalf) d = d + AngleFull;
    if (w ? reverse_r : reverse_l) d = -d;
    last_angle[w] = ang;
    scaled = clamp_int32(round_half_up(d * longint'({32'b0, mm_per_count}), ScaleShift));
    unity = ALPHA_ONE;
    if (lowpass_weight > ALPHA_ONE) a = unity;
    else a = lowpass_weight;
    acc = a * scaled + (unity - a) * smoothed_speed[w];
    v = clamp_int32(round_half_up(acc, AlphaShift));
    smoothed_speed[w] = v;
    r.wheel    = w;
    r.angle    = ang[AngleOutW-1:0];
    r.delta    = d[DeltaOutW-1:0];
    r.velocity = v[VelW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    wheel_speed_t want;
    if (!rst_n) begin
      reverse_l      = 1'b0;
      reverse_r      = 1'b0;
      mm_per_count   = SCALE_RESET;
      lowpass_weight = ALPHA_RESET;
      for (int i = 0; i < 2; i++) begin
        last_angle[i]     = 0;
        smoothed_speed[i] = 0;
        seen_sample[i]    = 1'b0;
      end
      expected_speeds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REVERSE_LEFT:   reverse_l = cfg_wdata[0];
          REG_REVERSE_RIGHT:  reverse_r = cfg_wdata[0];
          REG_VELOCITY_SCALE: mm_per_count = cfg_wdata[ScaleW-1:0];
          REG_FILTER_ALPHA:   lowpass_weight = cfg_wdata[AlphaW-1:0];
          default: ;
        endcase
      end
      // result side first: a result never stems from a transfer at the same edge
      if (out_valid && out_ready) begin
        if (expected_speeds.size() == 0) begin
          report_mismatch($sformatf("result for wheel %0d with none pending", out_wheel_out));
        end else begin
          want = expected_speeds.pop_front();
          if (out_wheel_out !== want.wheel)
            report_mismatch($sformatf("wheel_out got %0d want %0d", out_wheel_out, want.wheel));
          if (out_angle !== want.angle)
            report_mismatch($sformatf("angle got %0d want %0d", out_angle, want.angle));
          if (out_count_delta !== want.delta)
            report_mismatch($sformatf("count_delta got %0d want %0d",
                                      out_count_delta, want.delta));
          if (out_velocity !== want.velocity)
            report_mismatch($sformatf("velocity got %0d want %0d",
                                      out_velocity, want.velocity));
        end
      end
      if (in_valid && in_ready)
        expected_speeds.push_back(estimate_speed(in_wheel, in_raw_word));
    end
    results_pending <= expected_speeds.size();
    mismatch_total  <= mismatches;
  end

endmodule

@@ tb/sv/encoder_velocity_estimator_tb.sv @@
`timescale 1ns / 1ps

module encoder_velocity_estimator_tb;
  import evel_pkg::*;

  localparam int unsigned AngleBits     = 14;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned WatchdogLimit = 2000;  // cycles without any transfer
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 138;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CfgIdxW-1:0]          cfg_index = '0;
  logic [CfgDataW-1:0]         cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_wheel = 1'b0;
  logic [15:0]                 in_raw_word = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_wheel_out;
  logic [AngleOutW-1:0]        out_angle;
  logic signed [DeltaOutW-1:0] out_count_delta;
  logic signed [VelW-1:0]      out_velocity;

  int                          mismatch_total;
  int                          results_pending;
  int unsigned                 quiet_cycles = 0;
  // when set, neither side inserts idle cycles
  bit                          steady_flow = 1'b0;
  // angle each wheel was last sent at, used to shape realistic motion
  logic [13:0]                 track_angle[2] = '{14'd0, 14'd0};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  encoder_velocity_estimator #(
    .ANGLE_BITS(AngleBits)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_wheel        (in_wheel),
    .in_raw_word     (in_raw_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_wheel_out   (out_wheel_out),
    .out_angle       (out_angle),
    .out_count_delta (out_count_delta),
    .out_velocity    (out_velocity)
  );

  encoder_velocity_checker #(
    .ANGLE_BITS(AngleBits)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_wheel        (in_wheel),
    .in_raw_word     (in_raw_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_wheel_out   (out_wheel_out),
    .out_angle       (out_angle),
    .out_count_delta (out_count_delta),
    .out_velocity    (out_velocity),
    .mismatch_total  (mismatch_total),
    .results_pending (results_pending)
  );

  // one register write, enable held for a single edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drop valid, wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    // the pending count is registered, so it shows the last transfer only after the next edge
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // returns at the edge of the transfer with valid still high, so a
  // back-to-back sample keeps valid up without dropping it in between
  task automatic send_sample(logic w, logic [15:0] raw);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_wheel    <= w;
    in_raw_word <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // result side: random back-pressure before each transfer, none while steady_flow is set
  initial begin : result_sink
    int unsigned hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned sel;
    int          step;
    logic        w;
    logic [CfgDataW-1:0] scale_val;
    logic [CfgDataW-1:0] alpha_val;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: priming, wrap-around and the half-turn boundaries
    send_sample(1'b0, 16'hffff);   // first left sample only primes
    send_sample(1'b0, 16'h0000);   // wraps forward by one count
    send_sample(1'b1, 16'h0003);   // right primes at zero, low bits ignored
    send_sample(1'b1, 16'h8000);   // exactly plus half a turn, kept
    send_sample(1'b1, 16'h0001);   // exactly minus half a turn, kept
    send_sample(1'b1, 16'h8006);   // just over half a turn, wraps negative
    send_sample(1'b1, 16'h0002);   // just under minus half a turn, wraps positive
    send_sample(1'b0, 16'h5555);
    send_sample(1'b0, 16'haaaa);
    settle();

    // both wheels reversed, full-scale gain, alpha beyond one (used as one)
    write_reg(REG_REVERSE_LEFT, 32'h0000_0001);
    write_reg(REG_REVERSE_RIGHT, 32'hffff_ffff);
    write_reg(REG_VELOCITY_SCALE, 32'hffff_ffff);
    write_reg(REG_FILTER_ALPHA, 32'hffff_ffff);
    // indexes beyond the register map must be ignored
    for (int i = 4; i < 8; i++) write_reg(CfgIdxW'(i), $urandom());
    send_sample(1'b0, 16'h0000);   // saturates high or low
    send_sample(1'b0, 16'h8000);
    send_sample(1'b1, 16'h7ffc);
    send_sample(1'b1, 16'hfffc);
    send_sample(1'b0, 16'h0004);
    settle();

    // zero gain and zero alpha: the filter holds its last value
    write_reg(REG_REVERSE_LEFT, 32'hffff_fffe);   // only bit 0 counts
    write_reg(REG_REVERSE_RIGHT, 32'h0000_0000);
    write_reg(REG_VELOCITY_SCALE, 32'h0000_0000);
    write_reg(REG_FILTER_ALPHA, 32'h0000_0000);
    send_sample(1'b0, 16'h1234);
    send_sample(1'b1, 16'hedcb);
    send_sample(1'b0, 16'h4321);
    settle();

    // alpha exactly one, smallest non-zero gain
    write_reg(REG_VELOCITY_SCALE, 32'h0000_0001);
    write_reg(REG_FILTER_ALPHA, {15'd0, ALPHA_ONE});
    send_sample(1'b1, 16'h0000);
    send_sample(1'b0, 16'hc000);
    send_sample(1'b1, 16'h3ffc);
    settle();

    // random phases, each with fresh settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      steady_flow = (phase % 4 == 3);
      sel = (phase < 2) ? phase : $urandom_range(0, 4);
      case (sel)
        0:       scale_val = 32'hffff_ffff;
        1:       scale_val = 32'h0000_0000;
        2:       scale_val = SCALE_RESET;
        3:       scale_val = $urandom_range(0, 32'h0010_0000);
        default: scale_val = $urandom();
      endcase
      sel = (phase < 2) ? phase : $urandom_range(0, 4);
      case (sel)
        0:       alpha_val = {15'd0, ALPHA_ONE};
        1:       alpha_val = 32'h0000_0000;
        2:       alpha_val = $urandom();   // often above one
        default: alpha_val = $urandom_range(0, 65536);
      endcase
      write_reg(REG_REVERSE_LEFT, $urandom());
      write_reg(REG_REVERSE_RIGHT, $urandom());
      write_reg(REG_VELOCITY_SCALE, scale_val);
      write_reg(REG_FILTER_ALPHA, alpha_val);

      for (int n = 0; n < PhaseItems; n++) begin
        w    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // ordinary motion: a few hundred counts either way
          step = $urandom_range(0, 600);
          step = step - 300;
          track_angle[w] = track_angle[w] + 14'(step);
        end else if (pick == 7) begin
          // around half a turn, either side of the wrap boundary
          step = $urandom_range(8189, 8195);
          if ($urandom_range(0, 1)) step = -step;
          track_angle[w] = track_angle[w] + 14'(step);
        end else if (pick == 8) begin
          track_angle[w] = 14'($urandom());
        end
        // otherwise the wheel stands still
        send_sample(w, {track_angle[w], 2'($urandom())});
      end
      settle();
    end

    steady_flow = 1'b0;
    if (mismatch_total == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
